// File: sv/allpass_cascade_error_meter_unit_defines.svh
// Assertion macros shared by the all-pass error meter modules.
`ifndef ALLPASS_CASCADE_ERROR_METER_UNIT_DEFINES_SVH
`define ALLPASS_CASCADE_ERROR_METER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ACMU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ACMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/acmu_pkg.sv
// Package with widths, state encoding and control structs of the all-pass error meter.
`timescale 1ns / 1ps

package acmu_pkg;

   // Sample and section widths.
   localparam int SAMPLE_BITS     = 16;
   localparam int POLE_W          = 16;
   localparam int SEC_W           = SAMPLE_BITS + 2;
   localparam int DIFF_W          = SEC_W + 1;
   localparam int PROD_W          = POLE_W + DIFF_W;
   localparam int RND_W           = PROD_W - 14;
   localparam int TOT_W           = RND_W + 1;
   localparam int ERR_W           = SAMPLE_BITS + 1;
   localparam int MAG_W           = SAMPLE_BITS + 1;
   localparam int SQ_W            = 2 * MAG_W;
   localparam int SUM_W           = 48;
   localparam int MSE_W           = 35;
   localparam int ITER_W          = $clog2(SUM_W + 1);
   localparam int ROUND_BIAS      = 2 ** 14;
   localparam int MAX_SAMPLES_DEF = 4096;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SEC1,
      ST_MUL2,
      ST_SEC2,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic mul_one;
      logic sec_one;
      logic mul_two;
      logic sec_two;
      logic square;
      logic accum;
      logic div_start;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic div_final;
      logic out_free;
   } dp_status_type;

endpackage

// File: sv/acmu_if.sv
// Channel interfaces of the all-pass error meter: sample input, result output, pole register write.
`timescale 1ns / 1ps

interface acmu_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [acmu_pkg::SAMPLE_BITS-1:0]    sample;
   logic signed [acmu_pkg::SAMPLE_BITS-1:0]    reference;
   logic                                       last;

   modport source (output valid, sample, reference, last, input ready);
   modport sink   (input valid, sample, reference, last, output ready);
endinterface

interface acmu_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [acmu_pkg::SAMPLE_BITS-1:0]    filtered;
   logic        [acmu_pkg::MSE_W-1:0]          mean_sq_error;
   logic                                       block_end;

   modport source (output valid, filtered, mean_sq_error, block_end, input ready);
   modport sink   (input valid, filtered, mean_sq_error, block_end, output ready);
endinterface

interface acmu_csr_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [acmu_pkg::POLE_W-1:0]         data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: sv/acmu_ctrl.sv
// Controller state machine that sequences the filter, error and divide steps.
`timescale 1ns / 1ps
`include "allpass_cascade_error_meter_unit_defines.svh"

module acmu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  acmu_pkg::dp_status_type sts,
   output acmu_pkg::ctrl_cmd_type  cmd
);

   acmu_pkg::state_type state_ff;
   acmu_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acmu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acmu_pkg::ST_IDLE: begin
            if (req_valid) state_in = acmu_pkg::ST_MUL1;
         end
         acmu_pkg::ST_MUL1:   state_in = acmu_pkg::ST_SEC1;
         acmu_pkg::ST_SEC1:   state_in = acmu_pkg::ST_MUL2;
         acmu_pkg::ST_MUL2:   state_in = acmu_pkg::ST_SEC2;
         acmu_pkg::ST_SEC2:   state_in = acmu_pkg::ST_SQUARE;
         acmu_pkg::ST_SQUARE: state_in = acmu_pkg::ST_ACCUM;
         acmu_pkg::ST_ACCUM: begin
            state_in = sts.last ? acmu_pkg::ST_DIV_LOAD : acmu_pkg::ST_EMIT;
         end
         acmu_pkg::ST_DIV_LOAD: state_in = acmu_pkg::ST_DIVIDE;
         acmu_pkg::ST_DIVIDE: begin
            if (sts.div_final) state_in = acmu_pkg::ST_EMIT;
         end
         acmu_pkg::ST_EMIT: begin
            if (sts.out_free) state_in = acmu_pkg::ST_IDLE;
         end
         default: state_in = acmu_pkg::ST_IDLE;
      endcase
   end

   // Output decode: one command per state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         acmu_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         acmu_pkg::ST_MUL1:     cmd.mul_one   = 1'b1;
         acmu_pkg::ST_SEC1:     cmd.sec_one   = 1'b1;
         acmu_pkg::ST_MUL2:     cmd.mul_two   = 1'b1;
         acmu_pkg::ST_SEC2:     cmd.sec_two   = 1'b1;
         acmu_pkg::ST_SQUARE:   cmd.square    = 1'b1;
         acmu_pkg::ST_ACCUM:    cmd.accum     = 1'b1;
         acmu_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
         acmu_pkg::ST_DIVIDE:   cmd.div_step  = 1'b1;
         acmu_pkg::ST_EMIT:     cmd.emit      = sts.out_free;
         default: cmd = '0;
      endcase
   end

   // An accepted transaction starts the first multiply in the next cycle.
   `ACMU_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == acmu_pkg::ST_MUL1, "accepted transaction did not start the cascade")
   // The final divide step hands over to the result stage.
   `ACMU_ASSERT_NEXT(a_div_to_emit, clock, reset, (state_ff == acmu_pkg::ST_DIVIDE) && sts.div_final, state_ff == acmu_pkg::ST_EMIT, "divider finished without moving to the result stage")
   // A result waits while the output register is still occupied.
   `ACMU_ASSERT_NEXT(a_emit_holds, clock, reset, (state_ff == acmu_pkg::ST_EMIT) && !sts.out_free, state_ff == acmu_pkg::ST_EMIT, "result stage left while output register was busy")

endmodule

// File: sv/acmu_dpath.sv
// Datapath: pole register, two all-pass sections on one multiplier, error meter and divider.
`timescale 1ns / 1ps
`include "allpass_cascade_error_meter_unit_defines.svh"

module acmu_dpath #(
   parameter int MAX_SAMPLES = acmu_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  acmu_pkg::ctrl_cmd_type                  cmd,
   output acmu_pkg::dp_status_type                 sts,
   input  logic signed [acmu_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic signed [acmu_pkg::SAMPLE_BITS-1:0] req_reference,
   input  logic                                    req_last,
   acmu_csr_if.sink                                csr,
   acmu_rsp_if.source                              rsp
);

   localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int SAMPLE_W = acmu_pkg::SAMPLE_BITS;
   localparam int POLE_W   = acmu_pkg::POLE_W;
   localparam int SEC_W    = acmu_pkg::SEC_W;
   localparam int DIFF_W   = acmu_pkg::DIFF_W;
   localparam int PROD_W   = acmu_pkg::PROD_W;
   localparam int RND_W    = acmu_pkg::RND_W;
   localparam int TOT_W    = acmu_pkg::TOT_W;
   localparam int ERR_W    = acmu_pkg::ERR_W;
   localparam int MAG_W    = acmu_pkg::MAG_W;
   localparam int SQ_W     = acmu_pkg::SQ_W;
   localparam int SUM_W    = acmu_pkg::SUM_W;
   localparam int MSE_W    = acmu_pkg::MSE_W;
   localparam int ITER_W   = acmu_pkg::ITER_W;
   localparam int SEC_HI   = 2 ** (SEC_W - 1) - 1;
   localparam int SMP_HI   = 2 ** (SAMPLE_W - 1) - 1;

   // Round the Q.30 product half-up to Q.15, add the delayed input, saturate.
   function automatic logic signed [SEC_W-1:0] sec_finish(
      input logic signed [PROD_W-1:0] prod,
      input logic signed [SEC_W-1:0]  u_prev
   );
      logic signed [PROD_W:0]  biased;
      logic signed [RND_W-1:0] rounded;
      logic signed [TOT_W-1:0] total;
      biased  = (PROD_W + 1)'(prod) + $signed((PROD_W + 1)'(acmu_pkg::ROUND_BIAS));
      rounded = biased[PROD_W:15];
      total   = TOT_W'(rounded) + TOT_W'(u_prev);
      if (total > $signed(TOT_W'(SEC_HI))) begin
         return SEC_W'(SEC_HI);
      end else if (total < $signed(TOT_W'(-SEC_HI - 1))) begin
         return SEC_W'(-SEC_HI - 1);
      end
      return total[SEC_W-1:0];
   endfunction

   // Saturate a section output to the sample width.
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SEC_W-1:0] y
   );
      if (y > $signed(SEC_W'(SMP_HI))) begin
         return SAMPLE_W'(SMP_HI);
      end else if (y < $signed(SEC_W'(-SMP_HI - 1))) begin
         return SAMPLE_W'(-SMP_HI - 1);
      end
      return y[SAMPLE_W-1:0];
   endfunction

   // Registers and their next values.
   logic signed [POLE_W-1:0]   pole_ff, pole_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] ref_ff, ref_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] prev_x_ff, prev_x_in;
   logic signed [SEC_W-1:0]    prev_y1_ff, prev_y1_in;
   logic signed [SEC_W-1:0]    prev_y2_ff, prev_y2_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SEC_W-1:0]    y1_ff, y1_in;
   logic signed [SAMPLE_W-1:0] filt_ff, filt_in;
   logic        [SQ_W-1:0]     sq_ff, sq_in;
   logic        [SUM_W-1:0]    sum_ff, sum_in;
   logic        [CNT_W-1:0]    count_ff, count_in;
   logic        [SUM_W-1:0]    quo_ff, quo_in;
   logic        [CNT_W-1:0]    rem_ff, rem_in;
   logic        [ITER_W-1:0]   iter_ff, iter_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic        [MSE_W-1:0]    rsp_mse_ff, rsp_mse_in;
   logic                       rsp_end_ff, rsp_end_in;

   // Combinational helpers.
   logic signed [DIFF_W-1:0]   mul_diff;
   logic signed [PROD_W-1:0]   mul_out;
   logic signed [SEC_W-1:0]    sec_one_out;
   logic signed [SEC_W-1:0]    sec_two_out;
   logic signed [ERR_W-1:0]    err;
   logic        [MAG_W-1:0]    err_mag;
   logic        [SUM_W:0]      sum_total;
   logic        [CNT_W:0]      div_shift;
   logic        [CNT_W:0]      div_diff;
   logic                       div_ge;
   logic                       room;

   // Shared multiplier: pole times the section difference y_prev - u.
   always_comb begin
      if (cmd.mul_two) begin
         mul_diff = DIFF_W'(prev_y2_ff) - DIFF_W'(y1_ff);
      end else begin
         mul_diff = DIFF_W'(prev_y1_ff) - DIFF_W'(x_ff);
      end
      mul_out = PROD_W'(pole_ff) * PROD_W'(mul_diff);
   end

   // Section outputs from the registered product.
   assign sec_one_out = sec_finish(prod_ff, SEC_W'(prev_x_ff));
   assign sec_two_out = sec_finish(prod_ff, prev_y1_ff);

   // Error magnitude against the reference.
   always_comb begin
      err     = ERR_W'(filt_ff) - ERR_W'(ref_ff);
      err_mag = err[ERR_W-1] ? MAG_W'($unsigned(-err)) : MAG_W'($unsigned(err));
   end

   // Saturating accumulation and one restoring divide step.
   always_comb begin
      room      = count_ff < CNT_W'(MAX_SAMPLES);
      sum_total = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
      div_shift = {rem_ff, quo_ff[SUM_W-1]};
      div_diff  = div_shift - {1'b0, count_ff};
      div_ge    = div_shift >= {1'b0, count_ff};
   end

   // Next-value logic for every register.
   always_comb begin
      pole_in      = pole_ff;
      x_in         = x_ff;
      ref_in       = ref_ff;
      last_in      = last_ff;
      prev_x_in    = prev_x_ff;
      prev_y1_in   = prev_y1_ff;
      prev_y2_in   = prev_y2_ff;
      prod_in      = prod_ff;
      y1_in        = y1_ff;
      filt_in      = filt_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_mse_in   = rsp_mse_ff;
      rsp_end_in   = rsp_end_ff;

      // Pole register write.
      if (csr.valid) pole_in = csr.data;

      // Input capture.
      if (cmd.load_in) begin
         x_in    = req_sample;
         ref_in  = req_reference;
         last_in = req_last;
      end

      // Cascade steps.
      if (cmd.mul_one || cmd.mul_two) prod_in = mul_out;
      if (cmd.sec_one) y1_in = sec_one_out;
      if (cmd.sec_two) begin
         prev_x_in  = x_ff;
         prev_y1_in = y1_ff;
         prev_y2_in = sec_two_out;
         filt_in    = sat_sample(sec_two_out);
      end

      // Error meter.
      if (cmd.square) sq_in = SQ_W'(err_mag) * SQ_W'(err_mag);
      if (cmd.accum && room) begin
         sum_in   = sum_total[SUM_W] ? {SUM_W{1'b1}} : sum_total[SUM_W-1:0];
         count_in = count_ff + CNT_W'(1);
      end

      // Mean by restoring division, one quotient bit per cycle.
      if (cmd.div_start) begin
         quo_in  = sum_ff;
         rem_in  = '0;
         iter_in = ITER_W'(SUM_W);
      end
      if (cmd.div_step) begin
         quo_in  = {quo_ff[SUM_W-2:0], div_ge};
         rem_in  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
         iter_in = iter_ff - ITER_W'(1);
      end

      // Output register; the block clears its state at the end of a block.
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_filt_in  = filt_ff;
         rsp_mse_in   = last_ff ? quo_ff[MSE_W-1:0] : '0;
         rsp_end_in   = last_ff;
         if (last_ff) begin
            prev_x_in  = '0;
            prev_y1_in = '0;
            prev_y2_in = '0;
            sum_in     = '0;
            count_in   = '0;
         end
      end
   end

   // Control and filter state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pole_ff      <= '0;
         prev_x_ff    <= '0;
         prev_y1_ff   <= '0;
         prev_y2_ff   <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pole_ff      <= pole_in;
         prev_x_ff    <= prev_x_in;
         prev_y1_ff   <= prev_y1_in;
         prev_y2_ff   <= prev_y2_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      ref_ff      <= ref_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      y1_ff       <= y1_in;
      filt_ff     <= filt_in;
      sq_ff       <= sq_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_mse_ff  <= rsp_mse_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // Ports and status.
   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.filtered      = rsp_filt_ff;
   assign rsp.mean_sq_error = rsp_mse_ff;
   assign rsp.block_end     = rsp_end_ff;
   assign sts.last          = last_ff;
   assign sts.div_final     = iter_ff == ITER_W'(1);
   assign sts.out_free      = !rsp_valid_ff || rsp.ready;

   // The sample count never passes its limit.
   `ACMU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SAMPLES), "sample count passed its limit")
   // Closing a block leaves the meter cleared.
   `ACMU_ASSERT_NEXT(a_block_clear, clock, reset, cmd.emit && last_ff, (count_ff == '0) && (sum_ff == '0) && (prev_y2_ff == '0), "meter state not cleared after block end")
   // A divide always starts with the full number of quotient bits.
   `ACMU_ASSERT_NEXT(a_div_load, clock, reset, cmd.div_start, iter_ff == ITER_W'(SUM_W), "divider loaded with wrong step count")

endmodule

// File: sv/allpass_cascade_error_meter_unit.sv
// Top level of the all-pass cascade error meter: controller and datapath.
`timescale 1ns / 1ps

// Each transaction carries a Q1.15 sample and a reference; the block runs the sample
// through two first-order all-pass sections with the pole held in the single
// configuration register, returns the saturated filter output, and accumulates the
// squared error. One item is worked on at a time: between one acceptance and the next
// the controller runs its fixed sequence of a multiply and a finishing step for each
// of the two recursive sections, which share one multiplier, then the squaring, the
// accumulation and the hand-off to the output register. A transaction marked last
// also runs the mean squared error through a restoring divider that produces one of
// the 48 quotient bits per cycle; the meter and filter state are then cleared for
// the next block while the pole is kept. The result sits in an output register, so
// the next transaction can be accepted while a result still waits; that transaction's
// own result is then held back, and the input with it, until the waiting result is
// taken.
module allpass_cascade_error_meter_unit #(
   parameter int MAX_SAMPLES = acmu_pkg::MAX_SAMPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   acmu_csr_if.sink   csr_bus,
   acmu_req_if.sink   req_bus,
   acmu_rsp_if.source rsp_bus
);

   acmu_pkg::ctrl_cmd_type  cmd;
   acmu_pkg::dp_status_type sts;
   logic                    req_ready;

   // Sequencer.
   acmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // Arithmetic and storage.
   acmu_dpath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_sample    (req_bus.sample),
      .req_reference (req_bus.reference),
      .req_last      (req_bus.last),
      .csr           (csr_bus),
      .rsp           (rsp_bus)
   );

endmodule
